>>> rtl/gsm_septet_unpacker_macros.svh
// Assertion macros shared by the septet unpacker modules.
`ifndef GSM_SEPTET_UNPACKER_MACROS_SVH
`define GSM_SEPTET_UNPACKER_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define GSU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/gsu_pkg.sv
// Shared types, constants and the hex character decoder for the septet unpacker.
package gsu_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned OCTET_W   = 8;
    localparam int unsigned SEPTET_W  = 7;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned NIBBLE_W  = 4;
    localparam int unsigned IN_DATA_W = 24;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_F = 8'h46;
    localparam logic [CHAR_W-1:0] HEX_A_VALUE = 8'd10;

    localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd6;

    // One decoded octet worth of output: one or two septets.
    typedef struct packed {
        logic [SEPTET_W-1:0] sep0;
        logic [SEPTET_W-1:0] sep1;
        logic                two;
        logic                done0;
        logic                done1;
    } t_pair;

    function automatic logic [NIBBLE_W-1:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        begin
            v = '0;
            if (c >= CHAR_0 && c <= CHAR_9) begin
                v = c - CHAR_0;
            end else if (c >= CHAR_A && c <= CHAR_F) begin
                v = c - CHAR_A + HEX_A_VALUE;
            end
            hex_nibble = v[NIBBLE_W-1:0];
        end
    endfunction

endpackage

>>> rtl/gsu_unpack.sv
// Hex decode, septet extraction and message state; registers one septet pair.
`include "gsm_septet_unpacker_macros.svh"

module gsu_unpack (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [gsu_pkg::CHAR_W-1:0]         i_hex_high_char,
    input  logic [gsu_pkg::CHAR_W-1:0]         i_hex_low_char,
    input  logic                               i_message_start,
    input  logic [gsu_pkg::COUNT_W-1:0]        i_septet_total,
    output logic                               o_pair_valid,
    input  logic                               i_pair_take,
    output gsu_pkg::t_pair                     o_pair
);

    logic [gsu_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [gsu_pkg::OCTET_W-1:0] r_prev, n_prev;
    logic [gsu_pkg::COUNT_W-1:0] r_left, n_left;
    logic                        r_pair_valid, n_pair_valid;
    gsu_pkg::t_pair              r_pair, n_pair;

    logic                              accept;
    logic [gsu_pkg::PHASE_W-1:0]       phase;
    logic [gsu_pkg::OCTET_W-1:0]       prev;
    logic [gsu_pkg::COUNT_W-1:0]       left;
    logic [gsu_pkg::COUNT_W-1:0]       left1;
    logic [gsu_pkg::COUNT_W-1:0]       left2;
    logic [gsu_pkg::OCTET_W-1:0]       octet;
    logic [3:0]                        shamt;
    logic [2*gsu_pkg::OCTET_W-1:0]     window;
    logic                              emit;
    logic                              two;

    assign o_ready = !r_pair_valid || i_pair_take;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (i_message_start) begin
            phase = '0;
            prev  = '0;
            left  = i_septet_total;
        end else begin
            phase = (r_phase > gsu_pkg::PHASE_LAST) ? gsu_pkg::PHASE_LAST : r_phase;
            prev  = r_prev;
            left  = r_left;
        end
        octet  = {gsu_pkg::hex_nibble(i_hex_high_char), gsu_pkg::hex_nibble(i_hex_low_char)};
        shamt  = 4'd8 - {1'b0, phase};
        window = {octet, prev} >> shamt;
        emit   = (left != '0);
        left1  = left - 1'b1;
        left2  = left1 - 1'b1;
        two    = (phase == gsu_pkg::PHASE_LAST) && (left1 != '0);

        n_pair.sep0  = window[gsu_pkg::SEPTET_W-1:0];
        n_pair.sep1  = octet[gsu_pkg::OCTET_W-1:1];
        n_pair.two   = two;
        n_pair.done0 = (left1 == '0);
        n_pair.done1 = (left2 == '0);

        n_phase = r_phase;
        n_prev  = r_prev;
        n_left  = r_left;
        if (accept) begin
            if (emit) begin
                n_phase = (phase < gsu_pkg::PHASE_LAST) ? phase + 1'b1 : '0;
                n_prev  = octet;
                n_left  = two ? left2 : left1;
            end else begin
                n_phase = phase;
                n_prev  = prev;
                n_left  = left;
            end
        end

        if (accept && emit) begin
            n_pair_valid = 1'b1;
        end else if (i_pair_take) begin
            n_pair_valid = 1'b0;
        end else begin
            n_pair_valid = r_pair_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_prev       <= '0;
            r_left       <= '0;
            r_pair_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_prev       <= n_prev;
            r_left       <= n_left;
            r_pair_valid <= n_pair_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_pair <= n_pair;
        end
    end

    assign o_pair_valid = r_pair_valid;
    assign o_pair       = r_pair;

    `GSU_ASSERT(a_phase_range, i_clk, i_rst_n, r_phase != 3'd7, "shift phase reached seven")
    `GSU_ASSERT(a_empty_octet, i_clk, i_rst_n, accept && !emit |=> !r_pair_valid, "empty octet left a pair")
    `GSU_ASSERT(a_two_on_wrap, i_clk, i_rst_n, accept && emit && two |=> r_phase == '0, "two septets without phase wrap")

endmodule

>>> rtl/gsu_serializer.sv
// Holds one septet pair and sends its septets one per cycle while the output is ready.
`include "gsm_septet_unpacker_macros.svh"

module gsu_serializer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_pair_valid,
    output logic                               o_pair_take,
    input  gsu_pkg::t_pair                     i_pair,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [gsu_pkg::SEPTET_W-1:0]       o_septet,
    output logic                               o_run_last,
    output logic                               o_message_done
);

    logic           r_valid, n_valid;
    logic           r_idx, n_idx;
    gsu_pkg::t_pair r_pair;
    logic           last_beat;
    logic           take;

    assign last_beat   = r_valid && i_ready && (r_idx || !r_pair.two);
    assign take        = !r_valid || last_beat;
    assign o_pair_take = take && i_pair_valid;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (take) begin
            n_valid = i_pair_valid;
            n_idx   = 1'b0;
        end else if (r_valid && i_ready) begin
            n_idx = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pair_take) begin
            r_pair <= i_pair;
        end
    end

    assign o_valid        = r_valid;
    assign o_septet       = r_idx ? r_pair.sep1 : r_pair.sep0;
    assign o_run_last     = r_idx || !r_pair.two;
    assign o_message_done = r_idx ? r_pair.done1 : r_pair.done0;

    `GSU_ASSERT(a_idx_pair, i_clk, i_rst_n, r_valid && r_idx |-> r_pair.two, "second septet of a single")
    `GSU_ASSERT(a_done_last, i_clk, i_rst_n, o_valid && o_message_done |-> o_run_last, "message done mid octet")
    `GSU_ASSERT(a_second_follows, i_clk, i_rst_n, o_valid && i_ready && !o_run_last |=> o_valid && r_idx, "second septet lost")
    `GSU_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !r_valid, "output valid after reset")

endmodule

>>> rtl/gsm_septet_unpacker.sv
// Top level of the GSM 7-bit septet unpacker.
//
// channel | dir | tdata (low bit up)                      | tuser         | tlast
// s       | in  | hex_high_char, hex_low_char, septet_total | message_start | -
// m       | out | septet, 0 pad                           | message_done  | run_last
//
// One octet request per cycle is taken while the output drains; results pass
// through the unpack pair register and then the serializer pair register.
// An octet on phase six yields two septets unless only one remains; the output
// port sends them one at a time and holds the input back meanwhile.
// Reset (synchronous, low) clears phase, carry, count and both valid stages.
// A stalled output holds one pair in the serializer and one in the unpack stage.
module gsm_septet_unpacker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] hex_high_char, [15:8] hex_low_char, [23:16] septet_total
    input  logic [gsu_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // [0] message_start
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [6:0] septet, [7] zero
    output logic [gsu_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // [0] message_done
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);

    logic                          pair_valid;
    logic                          pair_take;
    gsu_pkg::t_pair                pair;
    logic [gsu_pkg::SEPTET_W-1:0]  septet;

    gsu_unpack u_unpack (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_tvalid),
        .o_ready         (o_s_tready),
        .i_hex_high_char (i_s_tdata[7:0]),
        .i_hex_low_char  (i_s_tdata[15:8]),
        .i_message_start (i_s_tuser),
        .i_septet_total  (i_s_tdata[23:16]),
        .o_pair_valid    (pair_valid),
        .i_pair_take     (pair_take),
        .o_pair          (pair)
    );

    gsu_serializer u_serializer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pair_valid   (pair_valid),
        .o_pair_take    (pair_take),
        .i_pair         (pair),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_septet       (septet),
        .o_run_last     (o_m_tlast),
        .o_message_done (o_m_tuser)
    );

    assign o_m_tdata = {1'b0, septet};

endmodule
